/* hw/rtl/graph_dfs_bfs_order_assert.svh */
// assertion helpers for the traversal block
`ifndef GRAPH_DFS_BFS_ORDER_ASSERT_SVH
`define GRAPH_DFS_BFS_ORDER_ASSERT_SVH

// consequent checked in the same cycle
`define GDBO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define GDBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gdbo_pkg.sv */
`default_nettype none
package gdbo_pkg;

  localparam int NODE_W        = 6;
  localparam int ACT_W         = 2;
  localparam int MAX_NODES_DEF = 32;

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic KIND_DEPTH   = 1'b0;
  localparam logic KIND_BREADTH = 1'b1;

  typedef struct packed {
    logic add;
    logic clear;
  } adj_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/gdbo_ffs.sv */
`default_nettype none
module gdbo_ffs
  import gdbo_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic [MAX_NODES-1:0]         vec,
  output logic                              hit,
  output logic [$clog2(MAX_NODES)-1:0]      idx
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int GRP   = 8;
  localparam int NGRP  = (MAX_NODES + GRP - 1) / GRP;
  localparam int PAD_W = NGRP * GRP;
  localparam int PIW   = $clog2(PAD_W);

  logic [PAD_W-1:0] pad;
  logic [NGRP-1:0]  grp_hit;
  logic [2:0]       grp_low [NGRP];
  logic [PIW-1:0]   idx_full;

  always_comb begin
    pad = '0;
    pad[MAX_NODES-1:0] = vec;
  end

  // lowest set bit inside each byte, groups are independent
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit[g] = |pad[g*GRP +: GRP];
      grp_low[g] = 3'd0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (pad[g*GRP + b]) grp_low[g] = 3'(b);
      end
    end
  end

  // then the lowest byte that has a bit
  always_comb begin
    idx_full = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit[g]) idx_full = PIW'(g * GRP) | PIW'(grp_low[g]);
    end
  end

  assign hit = |grp_hit;
  assign idx = IDX_W'(idx_full);

endmodule
`default_nettype wire

/* hw/rtl/gdbo_adj.sv */
`default_nettype none
module gdbo_adj
  import gdbo_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire adj_cmd_t                      cmd,
  input  wire logic [$clog2(MAX_NODES)-1:0]  a_idx,
  input  wire logic [$clog2(MAX_NODES)-1:0]  b_idx,
  input  wire logic [$clog2(MAX_NODES)-1:0]  rd_idx,
  output logic      [MAX_NODES-1:0]          rd_row
);

  logic [MAX_NODES-1:0] adj_r [MAX_NODES];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < MAX_NODES; i++) adj_r[i] <= '0;
    end else if (cmd.add) begin
      // undirected: both rows get the bit
      adj_r[a_idx][b_idx] <= 1'b1;
      adj_r[b_idx][a_idx] <= 1'b1;
    end
  end

  assign rd_row = adj_r[rd_idx];

endmodule
`default_nettype wire

/* hw/rtl/graph_dfs_bfs_order.sv */
`default_nettype none
// Depth-first then breadth-first visit order of an undirected graph on nodes
// 1..MAX_NODES. Busy never rises for add-edge and clear commands. A run from
// a start node reaching V nodes raises busy while it does each push after the
// start node and each pop of the depth-first stack, then each enqueue and each
// expansion of the breadth-first queue, each step spending one pass of the
// single shared find-first-unvisited-neighbor unit. The run emits 2*V beats
// on out_valid, at most one per cycle, depth-first beats first; out_last
// marks the final breadth-first beat. There is no backpressure: every beat
// must be taken in the cycle it is shown. Runs and adds with a node of 0 or
// above MAX_NODES, and the unused action code, do nothing.
module graph_dfs_bfs_order
  import gdbo_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [NODE_W-1:0] in_node_a,
  input  wire logic [NODE_W-1:0] in_node_b,
  output logic                   out_valid,
  output logic [NODE_W-1:0]      out_visited_node,
  output logic                   out_order_kind,
  output logic                   out_last
);

`include "graph_dfs_bfs_order_assert.svh"

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DFS  = 2'd1;
  localparam logic [1:0] ST_BFS  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [MAX_NODES-1:0] vis_r, vis_nxt;
  logic [CNT_W-1:0]     sp_r, sp_nxt;
  logic [CNT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     tail_r, tail_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [IDX_W-1:0]     start_r, start_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]    out_node_r, out_node_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [IDX_W-1:0]     stack_r [MAX_NODES];
  logic [IDX_W-1:0]     queue_r [MAX_NODES];
  logic                 stk_we, q_we;
  logic [IDX_W-1:0]     stk_waddr, stk_wdata, q_waddr, q_wdata;

  logic                 accept;
  logic                 a_ok, b_ok;
  logic [IDX_W-1:0]     a_idx, b_idx;
  logic [CNT_W-1:0]     sp_m1;
  logic [IDX_W-1:0]     top_idx, row_idx, q_head;
  logic [MAX_NODES-1:0] adj_row, scan_vec, hit_bit;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  adj_cmd_t             adj_cmd;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign a_ok  = (in_node_a != '0) && (32'(in_node_a) <= MAX_NODES);
  assign b_ok  = (in_node_b != '0) && (32'(in_node_b) <= MAX_NODES);
  assign a_idx = IDX_W'(in_node_a - NODE_W'(1));
  assign b_idx = IDX_W'(in_node_b - NODE_W'(1));

  assign sp_m1   = sp_r - CNT_W'(1);
  assign top_idx = stack_r[sp_m1[IDX_W-1:0]];
  assign q_head  = queue_r[head_r[IDX_W-1:0]];
  assign row_idx = (state_r == ST_DFS) ? top_idx : cur_r;

  gdbo_adj #(.MAX_NODES(MAX_NODES)) u_adj (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (adj_cmd),
    .a_idx  (a_idx),
    .b_idx  (b_idx),
    .rd_idx (row_idx),
    .rd_row (adj_row)
  );

  // smallest unvisited neighbor of the node being expanded
  assign scan_vec = adj_row & ~vis_r;

  gdbo_ffs #(.MAX_NODES(MAX_NODES)) u_ffs (
    .vec (scan_vec),
    .hit (hit),
    .idx (hit_idx)
  );

  assign hit_bit = MAX_NODES'(1) << hit_idx;

  always_comb begin
    state_nxt     = state_r;
    vis_nxt       = vis_r;
    sp_nxt        = sp_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    out_valid_nxt = 1'b0;
    out_node_nxt  = out_node_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = 1'b0;
    adj_cmd       = '0;
    stk_we        = 1'b0;
    stk_waddr     = sp_r[IDX_W-1:0];
    stk_wdata     = hit_idx;
    q_we          = 1'b0;
    q_waddr       = tail_r[IDX_W-1:0];
    q_wdata       = hit_idx;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_ADD:   adj_cmd.add = a_ok && b_ok;
            ACT_CLEAR: adj_cmd.clear = 1'b1;
            ACT_RUN: begin
              if (a_ok) begin
                start_nxt     = a_idx;
                vis_nxt       = MAX_NODES'(1) << a_idx;
                stk_we        = 1'b1;
                stk_waddr     = '0;
                stk_wdata     = a_idx;
                sp_nxt        = CNT_W'(1);
                out_valid_nxt = 1'b1;
                out_node_nxt  = NODE_W'(a_idx) + NODE_W'(1);
                out_kind_nxt  = KIND_DEPTH;
                state_nxt     = ST_DFS;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DFS: begin
        if (hit) begin
          vis_nxt       = vis_r | hit_bit;
          stk_we        = 1'b1;
          sp_nxt        = sp_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_node_nxt  = NODE_W'(hit_idx) + NODE_W'(1);
          out_kind_nxt  = KIND_DEPTH;
        end else begin
          sp_nxt = sp_m1;
          if (sp_r == CNT_W'(1)) begin
            // stack empties: start breadth-first with the start node in hand
            vis_nxt   = MAX_NODES'(1) << start_r;
            cur_nxt   = start_r;
            head_nxt  = '0;
            tail_nxt  = '0;
            state_nxt = ST_BFS;
          end
        end
      end
      ST_BFS: begin
        if (hit) begin
          vis_nxt  = vis_r | hit_bit;
          q_we     = 1'b1;
          tail_nxt = tail_r + CNT_W'(1);
        end else begin
          // node fully expanded, so it is known whether it is the final one
          out_valid_nxt = 1'b1;
          out_node_nxt  = NODE_W'(cur_r) + NODE_W'(1);
          out_kind_nxt  = KIND_BREADTH;
          out_last_nxt  = (head_r == tail_r);
          if (head_r == tail_r) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt  = q_head;
            head_nxt = head_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vis_r       <= '0;
      sp_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cur_r       <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vis_r       <= vis_nxt;
      sp_r        <= sp_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cur_r       <= cur_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_node_r <= out_node_nxt;
    out_kind_r <= out_kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_r[stk_waddr] <= stk_wdata;
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_r[q_waddr] <= q_wdata;
  end

  assign out_valid        = out_valid_r;
  assign out_visited_node = out_node_r;
  assign out_order_kind   = out_kind_r;
  assign out_last         = out_last_r;

  `GDBO_ASSERT_SAME(a_last_is_breadth, out_last, out_valid && (out_order_kind == KIND_BREADTH), "last beat not a breadth-first beat")
  `GDBO_ASSERT_SAME(a_last_ends_run, out_last, !busy, "still busy after last beat")
  `GDBO_ASSERT_SAME(a_dfs_stack_nonempty, state_r == ST_DFS, sp_r != '0, "depth-first walk with empty stack")
  `GDBO_ASSERT_SAME(a_queue_order, state_r == ST_BFS, tail_r >= head_r, "queue head passed tail")
  `GDBO_ASSERT_NEXT(a_run_emits_start, accept && (in_action == ACT_RUN) && a_ok, out_valid && (out_order_kind == KIND_DEPTH) && busy, "run did not emit start node")

endmodule
`default_nettype wire
